[sv/kts_pkg.sv]
// Shared types, codes and the step program of the two-state Kalman step core.
package kts_pkg;

   localparam int MAG_W   = 64;   // magnitude width fed to the multiplier
   localparam int PART_W  = 32;   // partial product slice width
   localparam int PC_W    = 7;
   localparam int CSR_IDX_W = 4;

   localparam logic [PC_W-1:0] LAST_STEP = 7'd79;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_NOISE_00 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_NOISE_01 = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_NOISE_10 = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_NOISE_11 = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_COV_00   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_COV_11   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_STATE_0  = 4'd7;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2,
      ALU_DIV = 2'd3
   } alu_op_type;

   typedef enum logic [5:0] {
      SRC_ZERO, SRC_ONE,
      SRC_A00, SRC_A01, SRC_A10, SRC_A11, SRC_B0, SRC_B1, SRC_C0, SRC_C1,
      SRC_CUR, SRC_E,
      SRC_X0, SRC_X1, SRC_P0, SRC_P1, SRC_P2, SRC_P3,
      SRC_Q0, SRC_Q1, SRC_Q2, SRC_Q3, SRC_RN,
      SRC_T, SRC_U, SRC_NX0, SRC_NX1,
      SRC_T00, SRC_T01, SRC_T10, SRC_T11,
      SRC_PP00, SRC_PP01, SRC_PP10, SRC_PP11,
      SRC_PC0, SRC_PC1, SRC_CP0, SRC_CP1, SRC_S, SRC_K0, SRC_K1,
      SRC_M00, SRC_M01, SRC_M10, SRC_M11
   } src_type;

   typedef struct packed {
      alu_op_type op;
      src_type    dst;
      src_type    src_a;
      src_type    src_b;
   } step_type;

   function automatic step_type kts_step(input logic [PC_W-1:0] pc);
      step_type s;
      case (pc)
         // predicted state
         7'd0:  s = '{ALU_MUL, SRC_U,    SRC_A00,  SRC_X0};
         7'd1:  s = '{ALU_MUL, SRC_T,    SRC_A01,  SRC_X1};
         7'd2:  s = '{ALU_ADD, SRC_T,    SRC_U,    SRC_T};
         7'd3:  s = '{ALU_MUL, SRC_U,    SRC_B0,   SRC_CUR};
         7'd4:  s = '{ALU_ADD, SRC_NX0,  SRC_T,    SRC_U};
         7'd5:  s = '{ALU_MUL, SRC_U,    SRC_A10,  SRC_X0};
         7'd6:  s = '{ALU_MUL, SRC_T,    SRC_A11,  SRC_X1};
         7'd7:  s = '{ALU_ADD, SRC_T,    SRC_U,    SRC_T};
         7'd8:  s = '{ALU_MUL, SRC_U,    SRC_B1,   SRC_CUR};
         7'd9:  s = '{ALU_ADD, SRC_NX1,  SRC_T,    SRC_U};
         // A*P
         7'd10: s = '{ALU_MUL, SRC_U,    SRC_A00,  SRC_P0};
         7'd11: s = '{ALU_MUL, SRC_T,    SRC_A01,  SRC_P2};
         7'd12: s = '{ALU_ADD, SRC_T00,  SRC_U,    SRC_T};
         7'd13: s = '{ALU_MUL, SRC_U,    SRC_A00,  SRC_P1};
         7'd14: s = '{ALU_MUL, SRC_T,    SRC_A01,  SRC_P3};
         7'd15: s = '{ALU_ADD, SRC_T01,  SRC_U,    SRC_T};
         7'd16: s = '{ALU_MUL, SRC_U,    SRC_A10,  SRC_P0};
         7'd17: s = '{ALU_MUL, SRC_T,    SRC_A11,  SRC_P2};
         7'd18: s = '{ALU_ADD, SRC_T10,  SRC_U,    SRC_T};
         7'd19: s = '{ALU_MUL, SRC_U,    SRC_A10,  SRC_P1};
         7'd20: s = '{ALU_MUL, SRC_T,    SRC_A11,  SRC_P3};
         7'd21: s = '{ALU_ADD, SRC_T11,  SRC_U,    SRC_T};
         // (A*P)*A' + Q
         7'd22: s = '{ALU_MUL, SRC_U,    SRC_T00,  SRC_A00};
         7'd23: s = '{ALU_MUL, SRC_T,    SRC_T01,  SRC_A01};
         7'd24: s = '{ALU_ADD, SRC_T,    SRC_U,    SRC_T};
         7'd25: s = '{ALU_ADD, SRC_PP00, SRC_T,    SRC_Q0};
         7'd26: s = '{ALU_MUL, SRC_U,    SRC_T00,  SRC_A10};
         7'd27: s = '{ALU_MUL, SRC_T,    SRC_T01,  SRC_A11};
         7'd28: s = '{ALU_ADD, SRC_T,    SRC_U,    SRC_T};
         7'd29: s = '{ALU_ADD, SRC_PP01, SRC_T,    SRC_Q1};
         7'd30: s = '{ALU_MUL, SRC_U,    SRC_T10,  SRC_A00};
         7'd31: s = '{ALU_MUL, SRC_T,    SRC_T11,  SRC_A01};
         7'd32: s = '{ALU_ADD, SRC_T,    SRC_U,    SRC_T};
         7'd33: s = '{ALU_ADD, SRC_PP10, SRC_T,    SRC_Q2};
         7'd34: s = '{ALU_MUL, SRC_U,    SRC_T10,  SRC_A10};
         7'd35: s = '{ALU_MUL, SRC_T,    SRC_T11,  SRC_A11};
         7'd36: s = '{ALU_ADD, SRC_T,    SRC_U,    SRC_T};
         7'd37: s = '{ALU_ADD, SRC_PP11, SRC_T,    SRC_Q3};
         // P*C' and C*P
         7'd38: s = '{ALU_MUL, SRC_U,    SRC_PP00, SRC_C0};
         7'd39: s = '{ALU_MUL, SRC_T,    SRC_PP01, SRC_C1};
         7'd40: s = '{ALU_ADD, SRC_PC0,  SRC_U,    SRC_T};
         7'd41: s = '{ALU_MUL, SRC_U,    SRC_PP10, SRC_C0};
         7'd42: s = '{ALU_MUL, SRC_T,    SRC_PP11, SRC_C1};
         7'd43: s = '{ALU_ADD, SRC_PC1,  SRC_U,    SRC_T};
         7'd44: s = '{ALU_MUL, SRC_U,    SRC_C0,   SRC_PP00};
         7'd45: s = '{ALU_MUL, SRC_T,    SRC_C1,   SRC_PP10};
         7'd46: s = '{ALU_ADD, SRC_CP0,  SRC_U,    SRC_T};
         7'd47: s = '{ALU_MUL, SRC_U,    SRC_C0,   SRC_PP01};
         7'd48: s = '{ALU_MUL, SRC_T,    SRC_C1,   SRC_PP11};
         7'd49: s = '{ALU_ADD, SRC_CP1,  SRC_U,    SRC_T};
         // innovation variance and gain
         7'd50: s = '{ALU_MUL, SRC_U,    SRC_CP0,  SRC_C0};
         7'd51: s = '{ALU_MUL, SRC_T,    SRC_CP1,  SRC_C1};
         7'd52: s = '{ALU_ADD, SRC_T,    SRC_U,    SRC_T};
         7'd53: s = '{ALU_ADD, SRC_S,    SRC_T,    SRC_RN};
         7'd54: s = '{ALU_DIV, SRC_K0,   SRC_PC0,  SRC_S};
         7'd55: s = '{ALU_DIV, SRC_K1,   SRC_PC1,  SRC_S};
         // state update
         7'd56: s = '{ALU_MUL, SRC_U,    SRC_K0,   SRC_E};
         7'd57: s = '{ALU_ADD, SRC_X0,   SRC_NX0,  SRC_U};
         7'd58: s = '{ALU_MUL, SRC_U,    SRC_K1,   SRC_E};
         7'd59: s = '{ALU_ADD, SRC_X1,   SRC_NX1,  SRC_U};
         // I - K*C
         7'd60: s = '{ALU_MUL, SRC_U,    SRC_K0,   SRC_C0};
         7'd61: s = '{ALU_SUB, SRC_M00,  SRC_ONE,  SRC_U};
         7'd62: s = '{ALU_MUL, SRC_U,    SRC_K0,   SRC_C1};
         7'd63: s = '{ALU_SUB, SRC_M01,  SRC_ZERO, SRC_U};
         7'd64: s = '{ALU_MUL, SRC_U,    SRC_K1,   SRC_C0};
         7'd65: s = '{ALU_SUB, SRC_M10,  SRC_ZERO, SRC_U};
         7'd66: s = '{ALU_MUL, SRC_U,    SRC_K1,   SRC_C1};
         7'd67: s = '{ALU_SUB, SRC_M11,  SRC_ONE,  SRC_U};
         // covariance update
         7'd68: s = '{ALU_MUL, SRC_U,    SRC_M00,  SRC_PP00};
         7'd69: s = '{ALU_MUL, SRC_T,    SRC_M01,  SRC_PP10};
         7'd70: s = '{ALU_ADD, SRC_P0,   SRC_U,    SRC_T};
         7'd71: s = '{ALU_MUL, SRC_U,    SRC_M00,  SRC_PP01};
         7'd72: s = '{ALU_MUL, SRC_T,    SRC_M01,  SRC_PP11};
         7'd73: s = '{ALU_ADD, SRC_P1,   SRC_U,    SRC_T};
         7'd74: s = '{ALU_MUL, SRC_U,    SRC_M10,  SRC_PP00};
         7'd75: s = '{ALU_MUL, SRC_T,    SRC_M11,  SRC_PP10};
         7'd76: s = '{ALU_ADD, SRC_P2,   SRC_U,    SRC_T};
         7'd77: s = '{ALU_MUL, SRC_U,    SRC_M10,  SRC_PP01};
         7'd78: s = '{ALU_MUL, SRC_T,    SRC_M11,  SRC_PP11};
         7'd79: s = '{ALU_ADD, SRC_P3,   SRC_U,    SRC_T};
         default: s = '{ALU_ADD, SRC_ZERO, SRC_ZERO, SRC_ZERO};
      endcase
      return s;
   endfunction

endpackage

[sv/kalman_two_state_step_core.sv]
// Top level of the two-state Kalman filter step core: sequencer, register file, ports.
//
//  channel | direction | handshake          | beat
//  req_    | in        | req_valid/ready    | op, A, B, C, current, innovation
//  rsp_    | out       | rsp_valid/ready    | est_0/1, gain_0/1, singular
//  csr_    | in        | csr_valid/ready    | csr_index, csr_data (always ready)
//
//  A filter step runs an 80-step program on one shared unit: 46 multiplies, two serial
//  divides and 32 adds, followed by a hand-over to the output register.
//  With a zero innovation variance each divide skips its loop and returns a zero gain.
//  A restart beat reloads state and covariance and goes straight to the hand-over.
//  The divider's one-bit-per-cycle loop and the four-slice multiplier set the step time.
//  Reset is synchronous; state, covariance and configuration registers clear to zero.
//  A finished result sits in the output register, so the next beat is taken while it waits;
//  a step that finishes while that result is still not taken holds in S_FIN.
module kalman_two_state_step_core #(
   parameter int DATA_WIDTH = 48,
   parameter int FRAC_BITS  = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [DATA_WIDTH-1:0]           req_trans_00,
   input  logic [DATA_WIDTH-1:0]           req_trans_01,
   input  logic [DATA_WIDTH-1:0]           req_trans_10,
   input  logic [DATA_WIDTH-1:0]           req_trans_11,
   input  logic [DATA_WIDTH-1:0]           req_ctrl_gain_0,
   input  logic [DATA_WIDTH-1:0]           req_ctrl_gain_1,
   input  logic [DATA_WIDTH-1:0]           req_meas_row_0,
   input  logic [DATA_WIDTH-1:0]           req_meas_row_1,
   input  logic [DATA_WIDTH-1:0]           req_drive_current,
   input  logic [DATA_WIDTH-1:0]           req_innovation,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [DATA_WIDTH-1:0]           rsp_est_0,
   output logic [DATA_WIDTH-1:0]           rsp_est_1,
   output logic [DATA_WIDTH-1:0]           rsp_gain_0,
   output logic [DATA_WIDTH-1:0]           rsp_gain_1,
   output logic                            rsp_singular,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [DATA_WIDTH-1:0]           csr_data
);

   localparam int PC_W = kts_pkg::PC_W;

   // fixed-point one, saturated when the fraction fills the word
   localparam logic [DATA_WIDTH-1:0] ONE_VAL = (FRAC_BITS > DATA_WIDTH - 2)
      ? {1'b0, {(DATA_WIDTH-1){1'b1}}}
      : (DATA_WIDTH'(1) << FRAC_BITS);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_WAIT  = 4'b0100,
      S_FIN   = 4'b1000
   } seq_state_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] a00, a01, a10, a11, b0, b1, c0, c1, cur, e;
      logic [DATA_WIDTH-1:0] x0, x1, p0, p1, p2, p3;
      logic [DATA_WIDTH-1:0] t, u, nx0, nx1, t00, t01, t10, t11;
      logic [DATA_WIDTH-1:0] pp00, pp01, pp10, pp11, pc0, pc1, cp0, cp1, s;
      logic [DATA_WIDTH-1:0] k0, k1, m00, m01, m10, m11;
   } work_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] q0, q1, q2, q3, rn, ic00, ic11, is0;
   } cfg_type;

   seq_state_type           state_ff, state_in;
   logic [PC_W-1:0]         pc_ff, pc_in;
   work_type                work_ff, work_in;
   cfg_type                 cfg_ff, cfg_in;
   logic                    sing_ff, sing_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]   est0_ff, est0_in, est1_ff, est1_in;
   logic [DATA_WIDTH-1:0]   gain0_ff, gain0_in, gain1_ff, gain1_in;
   logic                    rsp_sing_ff, rsp_sing_in;

   kts_pkg::step_type       step;
   logic [DATA_WIDTH-1:0]   alu_a, alu_b, alu_y;
   logic                    alu_start, alu_done;
   logic                    req_acc, rsp_free;

   function automatic logic [DATA_WIDTH-1:0] rd(input kts_pkg::src_type sel,
                                                input work_type w, input cfg_type c);
      case (sel)
         kts_pkg::SRC_ZERO: return '0;
         kts_pkg::SRC_ONE:  return ONE_VAL;
         kts_pkg::SRC_A00:  return w.a00;
         kts_pkg::SRC_A01:  return w.a01;
         kts_pkg::SRC_A10:  return w.a10;
         kts_pkg::SRC_A11:  return w.a11;
         kts_pkg::SRC_B0:   return w.b0;
         kts_pkg::SRC_B1:   return w.b1;
         kts_pkg::SRC_C0:   return w.c0;
         kts_pkg::SRC_C1:   return w.c1;
         kts_pkg::SRC_CUR:  return w.cur;
         kts_pkg::SRC_E:    return w.e;
         kts_pkg::SRC_X0:   return w.x0;
         kts_pkg::SRC_X1:   return w.x1;
         kts_pkg::SRC_P0:   return w.p0;
         kts_pkg::SRC_P1:   return w.p1;
         kts_pkg::SRC_P2:   return w.p2;
         kts_pkg::SRC_P3:   return w.p3;
         kts_pkg::SRC_Q0:   return c.q0;
         kts_pkg::SRC_Q1:   return c.q1;
         kts_pkg::SRC_Q2:   return c.q2;
         kts_pkg::SRC_Q3:   return c.q3;
         kts_pkg::SRC_RN:   return c.rn;
         kts_pkg::SRC_T:    return w.t;
         kts_pkg::SRC_U:    return w.u;
         kts_pkg::SRC_NX0:  return w.nx0;
         kts_pkg::SRC_NX1:  return w.nx1;
         kts_pkg::SRC_T00:  return w.t00;
         kts_pkg::SRC_T01:  return w.t01;
         kts_pkg::SRC_T10:  return w.t10;
         kts_pkg::SRC_T11:  return w.t11;
         kts_pkg::SRC_PP00: return w.pp00;
         kts_pkg::SRC_PP01: return w.pp01;
         kts_pkg::SRC_PP10: return w.pp10;
         kts_pkg::SRC_PP11: return w.pp11;
         kts_pkg::SRC_PC0:  return w.pc0;
         kts_pkg::SRC_PC1:  return w.pc1;
         kts_pkg::SRC_CP0:  return w.cp0;
         kts_pkg::SRC_CP1:  return w.cp1;
         kts_pkg::SRC_S:    return w.s;
         kts_pkg::SRC_K0:   return w.k0;
         kts_pkg::SRC_K1:   return w.k1;
         kts_pkg::SRC_M00:  return w.m00;
         kts_pkg::SRC_M01:  return w.m01;
         kts_pkg::SRC_M10:  return w.m10;
         kts_pkg::SRC_M11:  return w.m11;
         default:           return '0;
      endcase
   endfunction

   assign step      = kts_pkg::kts_step(pc_ff);
   assign alu_a     = rd(step.src_a, work_ff, cfg_ff);
   assign alu_b     = rd(step.src_b, work_ff, cfg_ff);
   assign alu_start = (state_ff == S_ISSUE);

   kts_alu #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .op     (step.op),
      .opa    (alu_a),
      .opb    (alu_b),
      .done   (alu_done),
      .result (alu_y)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            kts_pkg::CSR_PROC_NOISE_00: cfg_in.q0   = csr_data;
            kts_pkg::CSR_PROC_NOISE_01: cfg_in.q1   = csr_data;
            kts_pkg::CSR_PROC_NOISE_10: cfg_in.q2   = csr_data;
            kts_pkg::CSR_PROC_NOISE_11: cfg_in.q3   = csr_data;
            kts_pkg::CSR_MEAS_NOISE:    cfg_in.rn   = csr_data;
            kts_pkg::CSR_INIT_COV_00:   cfg_in.ic00 = csr_data;
            kts_pkg::CSR_INIT_COV_11:   cfg_in.ic11 = csr_data;
            kts_pkg::CSR_INIT_STATE_0:  cfg_in.is0  = csr_data;
            default: ;  // indexes past the list are dropped
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      work_in      = work_ff;
      sing_in      = sing_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      est0_in      = est0_ff;
      est1_in      = est1_ff;
      gain0_in     = gain0_ff;
      gain1_in     = gain1_ff;
      rsp_sing_in  = rsp_sing_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               work_in.a00 = req_trans_00;
               work_in.a01 = req_trans_01;
               work_in.a10 = req_trans_10;
               work_in.a11 = req_trans_11;
               work_in.b0  = req_ctrl_gain_0;
               work_in.b1  = req_ctrl_gain_1;
               work_in.c0  = req_meas_row_0;
               work_in.c1  = req_meas_row_1;
               work_in.cur = req_drive_current;
               work_in.e   = req_innovation;
               pc_in       = '0;
               if (req_op) begin
                  // restart: reload state and diagonal covariance
                  work_in.x0 = cfg_ff.is0;
                  work_in.x1 = '0;
                  work_in.p0 = cfg_ff.ic00;
                  work_in.p1 = '0;
                  work_in.p2 = '0;
                  work_in.p3 = cfg_ff.ic11;
                  work_in.k0 = '0;
                  work_in.k1 = '0;
                  sing_in    = 1'b0;
                  state_in   = S_FIN;
               end else begin
                  state_in = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (alu_done) begin
               case (step.dst)
                  kts_pkg::SRC_X0:   work_in.x0   = alu_y;
                  kts_pkg::SRC_X1:   work_in.x1   = alu_y;
                  kts_pkg::SRC_P0:   work_in.p0   = alu_y;
                  kts_pkg::SRC_P1:   work_in.p1   = alu_y;
                  kts_pkg::SRC_P2:   work_in.p2   = alu_y;
                  kts_pkg::SRC_P3:   work_in.p3   = alu_y;
                  kts_pkg::SRC_T:    work_in.t    = alu_y;
                  kts_pkg::SRC_U:    work_in.u    = alu_y;
                  kts_pkg::SRC_NX0:  work_in.nx0  = alu_y;
                  kts_pkg::SRC_NX1:  work_in.nx1  = alu_y;
                  kts_pkg::SRC_T00:  work_in.t00  = alu_y;
                  kts_pkg::SRC_T01:  work_in.t01  = alu_y;
                  kts_pkg::SRC_T10:  work_in.t10  = alu_y;
                  kts_pkg::SRC_T11:  work_in.t11  = alu_y;
                  kts_pkg::SRC_PP00: work_in.pp00 = alu_y;
                  kts_pkg::SRC_PP01: work_in.pp01 = alu_y;
                  kts_pkg::SRC_PP10: work_in.pp10 = alu_y;
                  kts_pkg::SRC_PP11: work_in.pp11 = alu_y;
                  kts_pkg::SRC_PC0:  work_in.pc0  = alu_y;
                  kts_pkg::SRC_PC1:  work_in.pc1  = alu_y;
                  kts_pkg::SRC_CP0:  work_in.cp0  = alu_y;
                  kts_pkg::SRC_CP1:  work_in.cp1  = alu_y;
                  kts_pkg::SRC_S: begin
                     work_in.s = alu_y;
                     sing_in   = (alu_y == '0);
                  end
                  kts_pkg::SRC_K0:   work_in.k0   = alu_y;
                  kts_pkg::SRC_K1:   work_in.k1   = alu_y;
                  kts_pkg::SRC_M00:  work_in.m00  = alu_y;
                  kts_pkg::SRC_M01:  work_in.m01  = alu_y;
                  kts_pkg::SRC_M10:  work_in.m10  = alu_y;
                  kts_pkg::SRC_M11:  work_in.m11  = alu_y;
                  default: ;
               endcase
               if (pc_ff == kts_pkg::LAST_STEP) begin
                  state_in = S_FIN;
               end else begin
                  pc_in    = pc_ff + 1'b1;
                  state_in = S_ISSUE;
               end
            end
         end
         S_FIN: begin
            // hand over once the output register is free
            if (rsp_free) begin
               est0_in      = work_ff.x0;
               est1_in      = work_ff.x1;
               gain0_in     = work_ff.k0;
               gain1_in     = work_ff.k1;
               rsp_sing_in  = sing_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         work_ff      <= '0;
         cfg_ff       <= '0;
         sing_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         work_ff      <= work_in;
         cfg_ff       <= cfg_in;
         sing_ff      <= sing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      est0_ff     <= est0_in;
      est1_ff     <= est1_in;
      gain0_ff    <= gain0_in;
      gain1_ff    <= gain1_in;
      rsp_sing_ff <= rsp_sing_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_est_0    = est0_ff;
   assign rsp_est_1    = est1_ff;
   assign rsp_gain_0   = gain0_ff;
   assign rsp_gain_1   = gain1_ff;
   assign rsp_singular = rsp_sing_ff;

`ifndef SYNTH
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == S_WAIT))
      else $error("unit result with no step waiting");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (pc_ff <= kts_pkg::LAST_STEP))
      else $error("step counter past program end");

   a_fin_delivers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FIN) && rsp_free) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("finished step not delivered");

   a_single_sing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sing_ff) |-> ((rsp_gain_0 == '0) && (rsp_gain_1 == '0)))
      else $error("singular result with nonzero gain");
`endif

endmodule

[sv/kts_alu.sv]
// Shared saturating fixed-point unit: add, subtract, multi-cycle multiply, serial divide.
module kts_alu #(
   parameter int DATA_WIDTH = 48,
   parameter int FRAC_BITS  = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  kts_pkg::alu_op_type   op,
   input  logic [DATA_WIDTH-1:0] opa,
   input  logic [DATA_WIDTH-1:0] opb,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int NUM_W  = DATA_WIDTH + FRAC_BITS;
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam int WIDE_W = 2 * kts_pkg::MAG_W + 1;
   localparam int MAG_W  = kts_pkg::MAG_W;
   localparam int PART_W = kts_pkg::PART_W;

   typedef enum logic [4:0] {
      A_IDLE = 5'b00001,
      A_MUL  = 5'b00010,
      A_MPK  = 5'b00100,
      A_DIV  = 5'b01000,
      A_DPK  = 5'b10000
   } alu_state_type;

   alu_state_type st_ff, st_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [MAG_W-1:0]      ma_ff, ma_in, mb_ff, mb_in, prod_ff, prod_in;
   logic [2*MAG_W-1:0]    acc_ff, acc_in;
   logic [NUM_W-1:0]      num_ff, num_in, quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in, result_ff, result_in;
   logic                  done_ff, done_in;

   function automatic logic [DATA_WIDTH-1:0] magn(input logic [DATA_WIDTH-1:0] x);
      return x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
   endfunction

   // saturate a sign and magnitude into the data width
   function automatic logic [DATA_WIDTH-1:0] pack(input logic neg,
                                                  input logic [WIDE_W-1:0] mag);
      logic [WIDE_W-1:0] lim;
      logic [WIDE_W-1:0] m;
      lim = (WIDE_W'(1) << (DATA_WIDTH - 1)) - (neg ? WIDE_W'(0) : WIDE_W'(1));
      m   = (mag > lim) ? lim : mag;
      return neg ? (~m[DATA_WIDTH-1:0] + 1'b1) : m[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [DATA_WIDTH-1:0] sat_sum(input logic [DATA_WIDTH:0] s);
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                              : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
      return s[DATA_WIDTH-1:0];
   endfunction

   logic [1:0]            cur_k, prev_k;
   logic [CNT_W-1:0]      cnt_m1;
   logic [PART_W-1:0]     part_a, part_b;
   logic [2*MAG_W-1:0]    addend;
   logic [WIDE_W-1:0]     rnd;
   logic [DATA_WIDTH:0]   r2, dvs;
   logic                  ge;

   always_comb begin
      cur_k  = cnt_ff[1:0];
      cnt_m1 = cnt_ff - 1'b1;
      prev_k = cnt_m1[1:0];
      part_a = cur_k[0] ? ma_ff[MAG_W-1:PART_W] : ma_ff[PART_W-1:0];
      part_b = cur_k[1] ? mb_ff[MAG_W-1:PART_W] : mb_ff[PART_W-1:0];
      addend = {{MAG_W{1'b0}}, prod_ff} << (PART_W * (int'(prev_k[0]) + int'(prev_k[1])));
      rnd    = {1'b0, acc_ff} + (WIDE_W'(1) << (FRAC_BITS - 1));
      r2     = {rem_ff, num_ff[NUM_W-1]};
      dvs    = {1'b0, mb_ff[DATA_WIDTH-1:0]};
      ge     = (r2 >= dvs);
   end

   always_comb begin
      st_in     = st_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      case (st_ff)
         A_IDLE: begin
            if (start) begin
               neg_in = opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
               cnt_in = '0;
               case (op)
                  kts_pkg::ALU_ADD: begin
                     result_in = sat_sum({opa[DATA_WIDTH-1], opa} + {opb[DATA_WIDTH-1], opb});
                     done_in   = 1'b1;
                  end
                  kts_pkg::ALU_SUB: begin
                     result_in = sat_sum({opa[DATA_WIDTH-1], opa} - {opb[DATA_WIDTH-1], opb});
                     done_in   = 1'b1;
                  end
                  kts_pkg::ALU_MUL: begin
                     ma_in  = MAG_W'(magn(opa));
                     mb_in  = MAG_W'(magn(opb));
                     acc_in = '0;
                     st_in  = A_MUL;
                  end
                  kts_pkg::ALU_DIV: begin
                     if (opb == '0) begin
                        // zero divisor: gain forced to zero
                        result_in = '0;
                        done_in   = 1'b1;
                     end else begin
                        num_in = {magn(opa), {FRAC_BITS{1'b0}}};
                        mb_in  = MAG_W'(magn(opb));
                        rem_in = '0;
                        quo_in = '0;
                        st_in  = A_DIV;
                     end
                  end
                  default: begin
                     result_in = '0;
                     done_in   = 1'b1;
                  end
               endcase
            end
         end
         A_MUL: begin
            // slice product now, accumulate the previous slice
            prod_in = MAG_W'(part_a) * MAG_W'(part_b);
            if (cnt_ff != '0) begin
               acc_in = acc_ff + addend;
            end
            if (cnt_ff == CNT_W'(4)) begin
               st_in = A_MPK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         A_MPK: begin
            result_in = pack(neg_ff, rnd >> FRAC_BITS);
            done_in   = 1'b1;
            st_in     = A_IDLE;
         end
         A_DIV: begin
            rem_in = ge ? DATA_WIDTH'(r2 - dvs) : r2[DATA_WIDTH-1:0];
            quo_in = {quo_ff[NUM_W-2:0], ge};
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               st_in = A_DPK;
            end
         end
         A_DPK: begin
            result_in = pack(neg_ff, WIDE_W'(quo_ff));
            done_in   = 1'b1;
            st_in     = A_IDLE;
         end
         default: begin
            st_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= A_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule
